// ----- hw/rtl/sdco_pkg.sv -----
// shared types, constants and helper functions for the shower direction pipeline
package sdco_pkg;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_STEPS = 48;
	// vector datapath width (Q40 components) and angle width (1e-12 degree units)
	localparam int VW = 44;
	localparam int AW = 50;
	// quotient bits of the units-to-output conversion
	localparam int QB = 25;
	// threshold width
	localparam int TW = VW - 33;
	localparam int FRONT_LAT = 3;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int DIV_LAT = 5;

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [AW-1:0] ang_t;

	localparam vec_t VEC_ONE = vec_t'(64'sd1 << 40);
	localparam ang_t DEG90 = 50'sd90000000000000;
	localparam ang_t DEG180 = 50'sd180000000000000;
	localparam ang_t DEG360 = 50'sd360000000000000;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic [63:0] DEG_PER_RAD_UNITS = 64'd57295779513082;
	localparam logic [63:0] FIVE_POW_12 = 64'd244140625;

	localparam ang_t ATAN_TAB [15] = '{
		50'sd45000000000000, 50'sd26565051177078, 50'sd14036243467926,
		50'sd7125016348902, 50'sd3576334374997, 50'sd1789910608246,
		50'sd895173710211, 50'sd447614170861, 50'sd223810500369,
		50'sd111905677066, 50'sd55952891894, 50'sd27976452617,
		50'sd13988227142, 50'sd6994113675, 50'sd3497056851
	};

	// elementary angle of one cordic step
	function automatic ang_t atan_step(input int i);
		logic [63:0] t;
		t = (DEG_PER_RAD_UNITS + (64'd1 << (i - 1))) >> i;
		if (i < 15)
			return ATAN_TAB[i[3:0]];
		return ang_t'(t);
	endfunction

	// remove the cordic gain, sign-magnitude, truncating toward zero
	function automatic vec_t gain_fix(input vec_t a);
		logic [VW-1:0] u;
		logic [VW-33:0] hi;
		logic [31:0] lo;
		logic [VW-3:0] ph;
		logic [61:0] pl;
		logic [VW-1:0] r;
		u = a < 0 ? VW'(-a) : VW'(a);
		hi = u[VW-1:32];
		lo = u[31:0];
		ph = hi * INV_GAIN_Q30;
		pl = lo * INV_GAIN_Q30;
		r = {ph, 2'b00} + VW'(pl[61:30]);
		return a < 0 ? -$signed(r) : $signed(r);
	endfunction

endpackage

// ----- hw/rtl/shower_direction_from_camera_offset_top.sv -----
// top level: shower direction from telescope pointing and camera offset
//
// Command channel: a transaction is taken at each rising edge with start high
// and busy low. busy is always low, so a new transaction may be issued in
// every cycle. Fields: pointing_zenith, pointing_azimuth, offset_y, offset_x.
// Result channel: done is high for one cycle while shower_zenith and
// shower_azimuth hold the result; results come in issue order, one per
// transaction, and the receiver has no way to hold them off.
// Throughput is one transaction per cycle. The pipeline is made of four
// cordic passes in series (48 steps plus fold and gain stages each), three
// input conversion stages, five glue stages and a five stage reciprocal
// multiply for the output scaling.
// Reset clears every valid bit, so transactions in flight at reset are
// dropped and done stays low until new work has passed the pipeline.
module shower_direction_from_camera_offset_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [22:0]         pointing_zenith,
	input  logic signed [25:0]  pointing_azimuth,
	input  logic signed [20:0]  offset_y,
	input  logic signed [20:0]  offset_x,
	output logic                done,
	output logic [23:0]         shower_zenith,
	output logic signed [25:0]  shower_azimuth
);
	import sdco_pkg::*;

	localparam int LAT = FRONT_LAT + 4 * CORDIC_LAT + 5 + DIV_LAT;
	localparam logic [6:0] TINY_Q40 = 7'd110;

	// front end
	logic f_valid;
	vec_t f_x, f_z;
	ang_t f_ang_ze, f_ang_az;
	logic [22:0] f_ze;
	logic signed [25:0] f_az;

	// first pass
	logic a_valid;
	vec_t a_m1, a_x, a_z0, a_y1, a_z1;
	ang_t a_ang_az;
	logic [22:0] a_ze;
	logic signed [25:0] a_az;

	// second pass
	logic b_valid;
	vec_t b_n, b_z1, b_x2, b_y2;
	logic [22:0] b_ze;
	logic signed [25:0] b_az;

	// glue stages
	logic v_s1, v_s2, v_s3, v_s4;
	logic [TW-1:0] thr_s1, thr_s2;
	vec_t x_s1, y_s1, z_s1;
	vec_t x_s2, y_s2, xz_s2, yz_s2, zz_s2;
	logic [22:0] ze_s1, ze_s2, ze_s3, ze_s4;
	logic signed [25:0] az_s1, az_s2, az_s3, az_s4;
	logic [VW+6:0] thr_prod;

	// third pass
	logic c_valid;
	vec_t c_r;
	logic [TW-1:0] c_thr;
	ang_t d_ang;
	vec_t d_zz;
	logic [22:0] d_ze;
	logic signed [25:0] d_az;

	vec_t rz, rz_s3, zz_s3;
	ang_t azv, azv_s3, azv_s4;
	logic rzero_s3, zzero_s3, rzero_s4, zzero_s4;

	// fourth pass
	logic e_valid;
	ang_t e_ang;
	ang_t e_azv;
	logic e_rzero, e_zzero;
	logic [22:0] e_ze;
	logic signed [25:0] e_az;
	ang_t zenv_s4;

	// output scaling
	logic q_valid;
	logic signed [QB:0] qa, qz;
	logic q_rzero, q_zzero;
	logic [22:0] q_ze;
	logic signed [25:0] q_az;

	function automatic logic [VW-1:0] mag_of(input vec_t v);
		return v < 0 ? VW'(-v) : VW'(v);
	endfunction

	// every transaction flows straight through the pipeline
	assign busy = 1'b0;

	sdco_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start),
		.ze         (pointing_zenith),
		.az         (pointing_azimuth),
		.oy         (offset_y),
		.ox         (offset_x),
		.out_valid  (f_valid),
		.out_x      (f_x),
		.out_z      (f_z),
		.out_ang_ze (f_ang_ze),
		.out_ang_az (f_ang_az),
		.out_ze_raw (f_ze),
		.out_az_raw (f_az)
	);

	// length of (x, 1) alongside the elevation turn of (1, z)
	sdco_vec #(.SW(2 * VW)) u_vec_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_x      (f_x),
		.in_y      (VEC_ONE),
		.in_side   ({f_x, f_z}),
		.out_valid (),
		.out_mag   (a_m1),
		.out_ang   (),
		.out_side  ({a_x, a_z0})
	);

	sdco_rot #(.SW(AW + 49)) u_rot_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_x      (VEC_ONE),
		.in_y      (f_z),
		.in_ang    (f_ang_ze),
		.in_side   ({f_ang_az, f_ze, f_az}),
		.out_valid (a_valid),
		.out_x     (a_y1),
		.out_y     (a_z1),
		.out_side  ({a_ang_az, a_ze, a_az})
	);

	// full vector length alongside the azimuth turn of (x, y)
	sdco_vec #(.SW(VW)) u_vec_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_valid),
		.in_x      (a_m1),
		.in_y      (a_z0),
		.in_side   (a_z1),
		.out_valid (),
		.out_mag   (b_n),
		.out_ang   (),
		.out_side  (b_z1)
	);

	sdco_rot #(.SW(49)) u_rot_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_valid),
		.in_x      (a_x),
		.in_y      (a_y1),
		.in_ang    (a_ang_az),
		.in_side   ({a_ze, a_az}),
		.out_valid (b_valid),
		.out_x     (b_x2),
		.out_y     (b_y2),
		.out_side  ({b_ze, b_az})
	);

	// small-value threshold, about 1e-10 of the vector length
	assign thr_prod = (VW + 7)'($unsigned(b_n)) * (VW + 7)'(TINY_Q40)
		+ ((VW + 7)'(1) << 39);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= b_valid;
			v_s2 <= v_s1;
			v_s3 <= c_valid;
			v_s4 <= e_valid;
			done <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		thr_s1 <= thr_prod[VW+6:40];
		x_s1 <= b_x2;
		y_s1 <= b_y2;
		z_s1 <= b_z1;
		ze_s1 <= b_ze;
		az_s1 <= b_az;

		thr_s2 <= thr_s1;
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		xz_s2 <= (mag_of(x_s1) < VW'(thr_s1)) ? '0 : x_s1;
		yz_s2 <= (mag_of(y_s1) < VW'(thr_s1)) ? '0 : y_s1;
		zz_s2 <= (mag_of(z_s1) < VW'(thr_s1)) ? '0 : z_s1;
		ze_s2 <= ze_s1;
		az_s2 <= az_s1;
	end

	// horizontal length from the unzeroed components
	sdco_vec #(.SW(TW)) u_vec_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_x      (x_s2),
		.in_y      (y_s2),
		.in_side   (thr_s2),
		.out_valid (c_valid),
		.out_mag   (c_r),
		.out_ang   (),
		.out_side  (c_thr)
	);

	// horizontal angle from the zeroed components
	sdco_vec #(.SW(VW + 49)) u_vec_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_x      (xz_s2),
		.in_y      (yz_s2),
		.in_side   ({zz_s2, ze_s2, az_s2}),
		.out_valid (),
		.out_mag   (),
		.out_ang   (d_ang),
		.out_side  ({d_zz, d_ze, d_az})
	);

	always_comb begin
		rz = ($unsigned(c_r) < VW'(c_thr)) ? '0 : c_r;
		// azimuth counted from north, folded into -180..180
		azv = DEG90 - d_ang;
		if (azv > DEG180)
			azv = azv - DEG360;
		if (azv < -DEG180)
			azv = -azv;
	end

	always_ff @(posedge clk) begin
		rz_s3 <= rz;
		zz_s3 <= d_zz;
		azv_s3 <= azv;
		rzero_s3 <= rz == '0;
		zzero_s3 <= d_zz == '0;
		ze_s3 <= d_ze;
		az_s3 <= d_az;
	end

	// elevation of the turned vector
	sdco_vec #(.SW(AW + 51)) u_vec_e (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_x      (rz_s3),
		.in_y      (zz_s3),
		.in_side   ({azv_s3, rzero_s3, zzero_s3, ze_s3, az_s3}),
		.out_valid (e_valid),
		.out_mag   (),
		.out_ang   (e_ang),
		.out_side  ({e_azv, e_rzero, e_zzero, e_ze, e_az})
	);

	always_ff @(posedge clk) begin
		zenv_s4 <= DEG90 - e_ang;
		azv_s4 <= e_azv;
		rzero_s4 <= e_rzero;
		zzero_s4 <= e_zzero;
		ze_s4 <= e_ze;
		az_s4 <= e_az;
	end

	sdco_div #(.SW(2)) u_div_az (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_val    (azv_s4),
		.in_side   ({rzero_s4, zzero_s4}),
		.out_valid (q_valid),
		.out_q     (qa),
		.out_side  ({q_rzero, q_zzero})
	);

	sdco_div #(.SW(49)) u_div_ze (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_val    (zenv_s4),
		.in_side   ({ze_s4, az_s4}),
		.out_valid (),
		.out_q     (qz),
		.out_side  ({q_ze, q_az})
	);

	// degenerate directions keep the pointing angle
	always_ff @(posedge clk) begin
		shower_azimuth <= q_rzero ? q_az : qa[25:0];
		shower_zenith <= q_zzero ? {1'b0, q_ze} : qz[23:0];
	end

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("transaction did not complete after the pipeline latency");

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result strobe without a matching transaction");

endmodule

// ----- hw/rtl/sdco_front.sv -----
// input conversion: offsets to radians, pointing angles to internal units
module sdco_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [22:0]          ze,
	input  logic signed [25:0]   az,
	input  logic signed [20:0]   oy,
	input  logic signed [20:0]   ox,
	output logic                 out_valid,
	output sdco_pkg::vec_t       out_x,
	output sdco_pkg::vec_t       out_z,
	output sdco_pkg::ang_t       out_ang_ze,
	output sdco_pkg::ang_t       out_ang_az,
	output logic [22:0]          out_ze_raw,
	output logic signed [25:0]   out_az_raw
);
	import sdco_pkg::*;

	localparam logic signed [35:0] RAD_Q40 = 36'sd19190098069;
	localparam logic [27:0] FIVE12_U = 28'(FIVE_POW_12);
	localparam logic signed [28:0] FIVE12_S = 29'(FIVE_POW_12);

	// shift right with rounding to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
		logic [63:0] m;
		m = v < 0 ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (s - 1))) >> s;
		return v < 0 ? -$signed(m) : $signed(m);
	endfunction

	logic v_s1, v_s2;
	logic signed [56:0] px_s1, py_s1;
	logic [50:0] pze_s1;
	logic signed [54:0] paz_s1;
	logic [22:0] ze_s1, ze_s2;
	logic signed [25:0] az_s1, az_s2;
	vec_t x_s2, z_s2;
	ang_t uze_s2, uaz_s2;
	ang_t naz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	assign naz = -uaz_s2;

	always_ff @(posedge clk) begin
		px_s1 <= ox * RAD_Q40;
		py_s1 <= oy * RAD_Q40;
		pze_s1 <= ze * FIVE12_U;
		paz_s1 <= az * FIVE12_S;
		ze_s1 <= ze;
		az_s1 <= az;

		x_s2 <= vec_t'(rnd_shr(64'(px_s1), ANGLE_FRAC_BITS));
		z_s2 <= -vec_t'(rnd_shr(64'(py_s1), ANGLE_FRAC_BITS));
		uze_s2 <= ang_t'(rnd_shr($signed({13'b0, pze_s1}), ANGLE_FRAC_BITS - 12));
		uaz_s2 <= ang_t'(rnd_shr(64'(paz_s1), ANGLE_FRAC_BITS - 12));
		ze_s2 <= ze_s1;
		az_s2 <= az_s1;

		out_x <= x_s2;
		out_z <= z_s2;
		out_ang_ze <= DEG90 - uze_s2;
		// wrap the azimuth turn into (-180, 180]
		if (naz > DEG180)
			out_ang_az <= naz - DEG360;
		else if (naz <= -DEG180)
			out_ang_az <= naz + DEG360;
		else
			out_ang_az <= naz;
		out_ze_raw <= ze_s2;
		out_az_raw <= az_s2;
	end

endmodule

// ----- hw/rtl/sdco_rot.sv -----
// pipelined cordic rotation of a 2d vector with gain correction
module sdco_rot #(
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  sdco_pkg::vec_t  in_x,
	input  sdco_pkg::vec_t  in_y,
	input  sdco_pkg::ang_t  in_ang,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output sdco_pkg::vec_t  out_x,
	output sdco_pkg::vec_t  out_y,
	output logic [SW-1:0]   out_side
);
	import sdco_pkg::*;

	logic valid_s [CORDIC_STEPS+1];
	vec_t x_s [CORDIC_STEPS+1];
	vec_t y_s [CORDIC_STEPS+1];
	ang_t a_s [CORDIC_STEPS+1];
	logic [SW-1:0] side_s [CORDIC_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CORDIC_STEPS; k++)
				valid_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
			for (int k = 0; k < CORDIC_STEPS; k++)
				valid_s[k+1] <= valid_s[k];
			out_valid <= valid_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		// turns beyond a quarter go through a negated vector
		side_s[0] <= in_side;
		if (in_ang > DEG90) begin
			x_s[0] <= -in_x;
			y_s[0] <= -in_y;
			a_s[0] <= in_ang - DEG180;
		end else if (in_ang < -DEG90) begin
			x_s[0] <= -in_x;
			y_s[0] <= -in_y;
			a_s[0] <= in_ang + DEG180;
		end else begin
			x_s[0] <= in_x;
			y_s[0] <= in_y;
			a_s[0] <= in_ang;
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			side_s[k+1] <= side_s[k];
			if (a_s[k] >= 0) begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				a_s[k+1] <= a_s[k] - atan_step(k);
			end else begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				a_s[k+1] <= a_s[k] + atan_step(k);
			end
		end
		out_x <= gain_fix(x_s[CORDIC_STEPS]);
		out_y <= gain_fix(y_s[CORDIC_STEPS]);
		out_side <= side_s[CORDIC_STEPS];
	end

endmodule

// ----- hw/rtl/sdco_vec.sv -----
// pipelined cordic vectoring: angle and gain-corrected length of a 2d vector
module sdco_vec #(
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  sdco_pkg::vec_t  in_x,
	input  sdco_pkg::vec_t  in_y,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output sdco_pkg::vec_t  out_mag,
	output sdco_pkg::ang_t  out_ang,
	output logic [SW-1:0]   out_side
);
	import sdco_pkg::*;

	logic valid_s [CORDIC_STEPS+1];
	logic zf_s [CORDIC_STEPS+1];
	vec_t x_s [CORDIC_STEPS+1];
	vec_t y_s [CORDIC_STEPS+1];
	ang_t a_s [CORDIC_STEPS+1];
	logic [SW-1:0] side_s [CORDIC_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CORDIC_STEPS; k++)
				valid_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
			for (int k = 0; k < CORDIC_STEPS; k++)
				valid_s[k+1] <= valid_s[k];
			out_valid <= valid_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		zf_s[0] <= (in_x == '0) && (in_y == '0);
		// bring the vector into the right half plane
		if (in_x < 0) begin
			if (in_y >= 0) begin
				x_s[0] <= in_y;
				y_s[0] <= -in_x;
				a_s[0] <= DEG90;
			end else begin
				x_s[0] <= -in_y;
				y_s[0] <= in_x;
				a_s[0] <= -DEG90;
			end
		end else begin
			x_s[0] <= in_x;
			y_s[0] <= in_y;
			a_s[0] <= '0;
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			side_s[k+1] <= side_s[k];
			zf_s[k+1] <= zf_s[k];
			if (y_s[k] >= 0) begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				a_s[k+1] <= a_s[k] + atan_step(k);
			end else begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				a_s[k+1] <= a_s[k] - atan_step(k);
			end
		end
		// the null vector has length and angle zero
		out_mag <= zf_s[CORDIC_STEPS] ? '0 : gain_fix(x_s[CORDIC_STEPS]);
		out_ang <= zf_s[CORDIC_STEPS] ? '0 : a_s[CORDIC_STEPS];
		out_side <= side_s[CORDIC_STEPS];
	end

endmodule

// ----- hw/rtl/sdco_div.sv -----
// pipelined conversion from internal angle units to output fixed point
module sdco_div #(
	parameter int SW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  sdco_pkg::ang_t        in_val,
	input  logic [SW-1:0]         in_side,
	output logic                  out_valid,
	output logic signed [sdco_pkg::QB:0] out_q,
	output logic [SW-1:0]         out_side
);
	import sdco_pkg::*;

	localparam int NW = QB + 28;
	localparam int HW = NW - 24;
	localparam logic [NW-1:0] DIVISOR = NW'(FIVE_POW_12);
	localparam logic [NW-1:0] HALF = DIVISOR >> 1;
	localparam logic [27:0] DIV_LO = 28'(FIVE_POW_12);
	// 2^56 over the divisor, applied to the dividend above bit 24
	localparam logic [HW-1:0] RECIP = HW'(295147905);

	logic v_s1, v_s2, v_s3, v_s4;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	logic [NW-1:0] num_s1, num_s2, num_s3;
	logic [2*HW-1:0] prod_s2;
	logic [QB-1:0] qe_s3, q_s4;
	logic [NW-1:0] qd_s3;
	logic [SW-1:0] side_s1, side_s2, side_s3, side_s4;
	logic [AW-1:0] mag_in;
	logic [NW-1:0] rem;

	assign mag_in = in_val < 0 ? AW'(-in_val) : AW'(in_val);
	// estimate is low by at most one
	assign rem = num_s3 - qd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= in_val < 0;
		num_s1 <= NW'({mag_in, {(ANGLE_FRAC_BITS - 12){1'b0}}}) + HALF;
		side_s1 <= in_side;

		neg_s2 <= neg_s1;
		num_s2 <= num_s1;
		prod_s2 <= num_s1[NW-1:24] * RECIP;
		side_s2 <= side_s1;

		neg_s3 <= neg_s2;
		num_s3 <= num_s2;
		qe_s3 <= prod_s2[QB+31:32];
		qd_s3 <= prod_s2[QB+31:32] * DIV_LO;
		side_s3 <= side_s2;

		neg_s4 <= neg_s3;
		q_s4 <= (rem >= DIVISOR) ? qe_s3 + QB'(1) : qe_s3;
		side_s4 <= side_s3;

		out_q <= neg_s4 ? -$signed({1'b0, q_s4}) : $signed({1'b0, q_s4});
		out_side <= side_s4;
	end

endmodule

// ----- sim/shower_direction_from_camera_offset_top_tb.sv -----
// testbench for the shower direction block: random and directed transactions, scoreboard check
module shower_direction_from_camera_offset_top_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1450;

	typedef struct {
		logic [23:0] zen;
		logic [25:0] azi;
	} dir_t;

	class direction_scoreboard;
		dir_t expected_dirs[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function longint step_angle(int i);
			case (i)
				0: return 64'sd45000000000000;
				1: return 64'sd26565051177078;
				2: return 64'sd14036243467926;
				3: return 64'sd7125016348902;
				4: return 64'sd3576334374997;
				5: return 64'sd1789910608246;
				6: return 64'sd895173710211;
				7: return 64'sd447614170861;
				8: return 64'sd223810500369;
				9: return 64'sd111905677066;
				10: return 64'sd55952891894;
				11: return 64'sd27976452617;
				12: return 64'sd13988227142;
				13: return 64'sd6994113675;
				14: return 64'sd3497056851;
				default: return (64'sd57295779513082 + (64'sd1 <<< (i - 1))) >>> i;
			endcase
		endfunction

		function longint round_shift(longint v, int s);
			longint unsigned u;
			u = v < 0 ? -v : v;
			if (s == 0)
				return v;
			u = (u + (64'd1 << (s - 1))) >> s;
			return v < 0 ? -longint'(u) : longint'(u);
		endfunction

		function longint round_div(longint v, longint d);
			longint unsigned u, q;
			u = v < 0 ? -v : v;
			q = (u + longint'(d) / 2) / d;
			return v < 0 ? -longint'(q) : longint'(q);
		endfunction

		function longint remove_gain(longint a);
			longint unsigned u, hi, lo, r;
			u = a < 0 ? -a : a;
			hi = u >> 32;
			lo = u & 64'hFFFF_FFFF;
			r = hi * 64'd652032874 * 4 + ((lo * 64'd652032874) >> 30);
			return a < 0 ? -longint'(r) : longint'(r);
		endfunction

		function void turn(inout longint x, inout longint y, input longint a);
			longint cx, cy, t;
			cx = x;
			cy = y;
			a = a % 64'sd360000000000000;
			if (a > 64'sd180000000000000) a -= 64'sd360000000000000;
			if (a <= -64'sd180000000000000) a += 64'sd360000000000000;
			if (a > 64'sd90000000000000) begin
				cx = -cx; cy = -cy; a -= 64'sd180000000000000;
			end
			if (a < -64'sd90000000000000) begin
				cx = -cx; cy = -cy; a += 64'sd180000000000000;
			end
			for (int i = 0; i < 48; i++) begin
				if (a >= 0) begin
					t = cx - (cy >>> i); cy = cy + (cx >>> i); a -= step_angle(i);
				end else begin
					t = cx + (cy >>> i); cy = cy - (cx >>> i); a += step_angle(i);
				end
				cx = t;
			end
			x = remove_gain(cx);
			y = remove_gain(cy);
		endfunction

		// atan2 with length
		function longint heading(longint x, longint y, output longint mag);
			longint acc, t;
			acc = 0;
			if (x == 0 && y == 0) begin
				mag = 0;
				return 0;
			end
			if (x < 0) begin
				if (y >= 0) begin
					t = y; y = -x; x = t; acc = 64'sd90000000000000;
				end else begin
					t = -y; y = x; x = t; acc = -64'sd90000000000000;
				end
			end
			for (int i = 0; i < 48; i++) begin
				if (y >= 0) begin
					t = x + (y >>> i); y = y - (x >>> i); acc += step_angle(i);
				end else begin
					t = x - (y >>> i); y = y + (x >>> i); acc -= step_angle(i);
				end
				x = t;
			end
			mag = remove_gain(x);
			return acc;
		endfunction

		function dir_t predict(logic [22:0] zr, logic signed [25:0] azr,
				logic signed [20:0] oyr, logic signed [20:0] oxr);
			longint x, y, z, m1, n, thr, r, scratch, ang, v, zu, au;
			dir_t d;
			x = round_shift(longint'(oxr) * 64'sd19190098069, 16);
			y = 64'sd1 <<< 40;
			z = -round_shift(longint'(oyr) * 64'sd19190098069, 16);
			void'(heading(x, y, m1));
			void'(heading(m1, z, n));
			thr = round_shift(n * 110, 40);
			zu = round_shift(longint'({1'b0, zr}) * 64'sd244140625, 4);
			au = round_shift(longint'(azr) * 64'sd244140625, 4);
			turn(y, z, 64'sd90000000000000 - zu);
			turn(x, y, -au);
			void'(heading(x, y, r));
			if (r < thr) r = 0;
			if ((x < 0 ? -x : x) < thr) x = 0;
			if ((y < 0 ? -y : y) < thr) y = 0;
			if ((z < 0 ? -z : z) < thr) z = 0;
			if (r == 0)
				d.azi = azr;
			else begin
				ang = heading(x, y, scratch);
				v = 64'sd90000000000000 - ang;
				if (v > 64'sd180000000000000) v -= 64'sd360000000000000;
				if (v < -64'sd180000000000000) v = -v;
				d.azi = 26'(round_div(v * 16, 64'sd244140625));
			end
			if (z == 0)
				d.zen = {1'b0, zr};
			else begin
				ang = heading(r, z, scratch);
				d.zen = 24'(round_div((64'sd90000000000000 - ang) * 16, 64'sd244140625));
			end
			return d;
		endfunction

		function void note_command(logic [22:0] zr, logic signed [25:0] azr,
				logic signed [20:0] oyr, logic signed [20:0] oxr);
			expected_dirs.push_back(predict(zr, azr, oyr, oxr));
		endfunction

		function void check_result(logic [23:0] zen, logic [25:0] azi);
			dir_t e;
			if (expected_dirs.size() == 0) begin
				$display("%0t: unexpected result zenith %h azimuth %h", $time, zen, azi);
				errors++;
				return;
			end
			e = expected_dirs.pop_front();
			if (zen !== e.zen) begin
				$display("%0t: shower_zenith expected %h actual %h", $time, e.zen, zen);
				errors++;
			end
			if (azi !== e.azi) begin
				$display("%0t: shower_azimuth expected %h actual %h", $time, e.azi, azi);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	logic [22:0] pointing_zenith;
	logic signed [25:0] pointing_azimuth;
	logic signed [20:0] offset_y, offset_x;
	logic [23:0] shower_zenith;
	logic signed [25:0] shower_azimuth;

	direction_scoreboard sb = new();
	int quiet_cycles = 0;

	shower_direction_from_camera_offset_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pointing_zenith(pointing_zenith), .pointing_azimuth(pointing_azimuth),
		.offset_y(offset_y), .offset_x(offset_x), .done(done),
		.shower_zenith(shower_zenith), .shower_azimuth(shower_azimuth)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_command(pointing_zenith, pointing_azimuth, offset_y, offset_x);
		if (arst_n && done)
			sb.check_result(shower_zenith, shower_azimuth);
		if (arst_n && ((start && !busy) || done))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic issue(logic [22:0] zr, logic signed [25:0] azr,
			logic signed [20:0] oyr, logic signed [20:0] oxr, bit may_idle);
		logic held;
		if (may_idle && $urandom_range(0, 99) < 10) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pointing_zenith <= zr;
		pointing_azimuth <= azr;
		offset_y <= oyr;
		offset_x <= oxr;
		do begin
			@(negedge clk);
			held = busy;
			@(posedge clk);
		end while (held);
	endtask

	function automatic logic signed [20:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return 21'($urandom);
			1, 2: return 21'($urandom_range(0, 200)) - 21'sd100;
			default: return 21'($urandom_range(0, 1048576)) - 21'sd524288;
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		pointing_zenith = '0;
		pointing_azimuth = '0;
		offset_y = '0;
		offset_x = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pointing straight up with no offset leaves no horizontal part
		issue(23'd0, 26'sd0, 21'sd0, 21'sd0, 0);
		issue(23'd0, 26'sd1234567, 21'sd0, 21'sd0, 0);
		// horizon pointing with no offset leaves no vertical part
		issue(23'd5898240, 26'sd0, 21'sd0, 21'sd0, 0);
		issue(23'd5898240, 26'sd23592960, 21'sd0, 21'sd0, 0);
		issue(23'd5898240, -26'sd11796480, 21'sd0, 21'sd0, 0);
		issue(23'd2949120, 26'sd11796480, 21'sd524288, 21'sd524288, 0);
		issue(23'd2949120, -26'sd11796480, -21'sd524288, -21'sd524288, 0);
		issue(23'd1310720, 26'sd5898240, 21'sd524288, -21'sd524288, 0);
		issue(23'd1310720, 26'sd17694720, -21'sd524288, 21'sd524288, 0);
		issue(23'd0, 26'sd0, 21'sd1, 21'sd0, 0);
		issue(23'd0, 26'sd0, 21'sd0, -21'sd1, 0);
		issue(23'h7fffff, 26'h1ffffff, 21'h0fffff, 21'h0fffff, 0);
		issue(23'h7fffff, 26'h2000000, 21'h100000, 21'h100000, 0);
		issue(23'd5898240, 26'sd11796480, 21'sd0, 21'sd65536, 0);
		issue(23'd65536, 26'sd0, -21'sd65536, 21'sd0, 0);
		issue(23'd3932160, 26'sd20000000, 21'sd300000, -21'sd100000, 0);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			logic [22:0] zr;
			logic signed [25:0] azr;
			zr = ($urandom_range(0, 19) == 0) ? 23'($urandom) : 23'($urandom_range(0, 5898240));
			azr = ($urandom_range(0, 19) == 0) ? 26'($urandom)
				: 26'($urandom_range(0, 35389440)) - 26'sd11796480;
			issue(zr, azr, pick_offset(), pick_offset(), !(k >= 400 && k < 700));
		end
		start <= 1'b0;

		while (sb.expected_dirs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_dirs.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/sdco_pkg.sv
hw/rtl/sdco_front.sv
hw/rtl/sdco_rot.sv
hw/rtl/sdco_vec.sv
hw/rtl/sdco_div.sv
hw/rtl/shower_direction_from_camera_offset_top.sv
sim/shower_direction_from_camera_offset_top_tb.sv
